// ===== sv/reliable_udp_receive_window_defines.svh =====
// ----------------------------------------------------------------------------
// Receive window assertion macros
// Shared concurrent assertion forms for the receive window block.
// ----------------------------------------------------------------------------
`ifndef RELIABLE_UDP_RECEIVE_WINDOW_DEFINES_SVH
`define RELIABLE_UDP_RECEIVE_WINDOW_DEFINES_SVH

// same-cycle implication
`define RURW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("receive window assertion failed");

// next-cycle implication
`define RURW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("receive window assertion failed");

`endif

// ===== sv/rurw_pkg.sv =====
// ----------------------------------------------------------------------------
// Receive window package
// Widths, defaults and status codes shared by the receive window files.
// ----------------------------------------------------------------------------
package rurw_pkg;

    localparam int WINDOW_DEF   = 64;
    localparam int CHANNELS_DEF = 8;
    localparam int SEQ_W        = 32;
    localparam int CHID_W       = 5;
    localparam int SLOT_OUT_W   = 9;

    localparam logic [SEQ_W-1:0] RANGE_RST = 32'd1024;

    typedef enum logic [2:0] {
        ST_DELIVER = 3'd0,
        ST_DUP     = 3'd1,
        ST_CACHED  = 3'd2,
        ST_OOW     = 3'd3,
        ST_BADCH   = 3'd4
    } t_status;

endpackage

// ===== sv/rurw_ifs.sv =====
// ----------------------------------------------------------------------------
// Receive window channels
// Header beat channel and verdict beat channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rurw_in_if import rurw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SEQ_W-1:0]  sequence_no;
    logic              reliable;
    logic              ordered;
    logic [CHID_W-1:0] channel_id;
    logic              chunk;

    modport source (output valid, sequence_no, reliable, ordered, channel_id, chunk,
                    input ready);
    modport sink   (input valid, sequence_no, reliable, ordered, channel_id, chunk,
                    output ready);
endinterface

interface rurw_out_if import rurw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_status               status;
    logic                  deliver;
    logic [SEQ_W-1:0]      delivered_seq;
    logic                  from_cache;
    logic [SLOT_OUT_W-1:0] buffer_slot;
    logic                  to_reassembly;
    logic                  last;

    modport source (output valid, status, deliver, delivered_seq, from_cache, buffer_slot,
                    to_reassembly, last, input ready);
    modport sink   (input valid, status, deliver, delivered_seq, from_cache, buffer_slot,
                    to_reassembly, last, output ready);
endinterface

// ===== sv/reliable_udp_receive_window.sv =====
// ----------------------------------------------------------------------------
// Reliable UDP receive window
// Sequence checks, duplicate filter and per-channel reorder slot tracking.
// ----------------------------------------------------------------------------
// One header beat is taken at a time; the block is busy until its verdicts are
// out. Unreliable headers, unordered headers that are not in order and ordered
// headers rejected as duplicate, out of window or bad channel get their verdict
// straight from the evaluate step. An unordered in-order header then absorbs
// its cached neighbors, one per step. An ordered header that goes to its slot
// (or is dropped as already held there) has its slot found, read and checked.
// An in-order ordered header then walks the slots that follow; the walk visits
// one slot-table entry per step through the single memory read port, and
// ends at the highest number seen, at its bound, or at a slot that does not
// hold the next number. When WINDOW is not a power of two the slot remainder
// comes from a reciprocal multiply and a correction step. A verdict beat held
// by a low ready stalls the block. After reset the slot table is swept clear,
// one entry per cycle, with ready held low.
module reliable_udp_receive_window import rurw_pkg::*; #(
    parameter int WINDOW   = WINDOW_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [SEQ_W-1:0] i_cfg_wdata,
    rurw_in_if.sink          i_pkt,
    rurw_out_if.source       o_vrd
);
    `include "reliable_udp_receive_window_defines.svh"

    localparam int NSLOTS = CHANNELS * WINDOW;
    localparam int SLOT_W = $clog2(NSLOTS);
    localparam int REM_W  = $clog2(WINDOW);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = $clog2(WINDOW);
    localparam bit POW2   = ((WINDOW & (WINDOW - 1)) == 0);
    localparam logic [SEQ_W-1:0] WIN   = SEQ_W'(WINDOW);
    localparam logic [SEQ_W-1:0] RECIP = SEQ_W'((64'd1 << SEQ_W) / 64'(WINDOW));

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EVAL, S_REM, S_RFIX, S_RDONE, S_RD, S_ORD,
        S_WCHK, S_WRD, S_WDEC, S_UWALK
    } t_state;

    typedef struct packed {
        logic             kept;
        logic [SEQ_W-1:0] seq;
    } t_slot;

    t_state r_state;

    logic [SEQ_W-1:0]  r_range;
    logic [SEQ_W-1:0]  r_seq;
    logic              r_rel, r_ord, r_chk;
    logic [CHID_W-1:0] r_ch;

    logic [SEQ_W-1:0]  r_unrel_exp;
    logic [SEQ_W-1:0]  r_unord_recv, r_unord_last;
    logic [WINDOW-1:0] r_unord_bm;
    logic [SEQ_W-1:0]  r_chan_recv [CHANNELS];
    logic [SEQ_W-1:0]  r_chan_last [CHANNELS];

    logic              r_upd, r_inord;
    logic [REM_W:0]    r_racc;
    logic [SEQ_W-1:0]  r_quo;
    logic [REM_W-1:0]  r_rem;
    logic [SEQ_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic [SLOT_W-1:0] r_addr;

    logic [SEQ_W-1:0]  r_p_seq;
    logic              r_p_fc;
    logic [SLOT_W-1:0] r_p_slot;

    logic              r_ov;
    t_status           r_o_status;
    logic              r_o_dv, r_o_fc, r_o_ra, r_o_last;
    logic [SEQ_W-1:0]  r_o_seq;
    logic [SLOT_W-1:0] r_o_slot;

    t_slot             r_mem [NSLOTS];
    t_slot             r_rd;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    t_slot             mem_wd;

    logic              out_free;
    logic [CH_W-1:0]   chi;
    logic [SEQ_W-1:0]  unrel_d, u_d, c_recv, c_last, c_d;
    logic              u_back, u_inord, ch_ok, c_back, c_inord;
    logic [REM_W-1:0]  bit_idx, rem_nx, rem_now;
    logic [REM_W:0]    racc_fix;
    logic [2*SEQ_W-1:0] prod;
    logic [SEQ_W-1:0]  rem_raw;
    logic [SLOT_W-1:0] base;

    always_comb begin
        out_free = !r_ov || o_vrd.ready;
        chi      = r_ch[CH_W-1:0];
        unrel_d  = r_seq - r_unrel_exp;
        u_d      = r_seq - r_unord_recv;
        u_back   = (r_unord_recv - r_seq) < WIN;
        u_inord  = (r_seq == r_unord_recv + 1'b1);
        bit_idx  = REM_W'(u_d - 1'b1);
        ch_ok    = {1'b0, r_ch} < (CHID_W + 1)'(CHANNELS);
        c_recv   = r_chan_recv[chi];
        c_last   = r_chan_last[chi];
        c_d      = r_seq - c_recv;
        c_back   = (c_recv - r_seq) < WIN;
        c_inord  = (r_seq == c_recv + 1'b1);
        base     = SLOT_W'(SLOT_W'(r_ch) * SLOT_W'(WINDOW));
        // quotient estimate is low by at most one, so one subtract corrects it
        prod     = (2*SEQ_W)'(r_seq) * (2*SEQ_W)'(RECIP);
        rem_raw  = r_seq - r_quo * WIN;
        racc_fix = (r_racc >= (REM_W + 1)'(WINDOW)) ?
                   r_racc - (REM_W + 1)'(WINDOW) : r_racc;
        rem_now  = racc_fix[REM_W-1:0];
        rem_nx   = (r_rem == REM_W'(WINDOW - 1)) ? '0 : r_rem + 1'b1;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = '0;
        case (r_state)
            S_CLEAR: mem_we = 1'b1;
            S_ORD: begin
                if (out_free && !(r_rd.kept && r_rd.seq == r_seq)) begin
                    mem_we = 1'b1;
                    mem_wd = '{kept: 1'b1, seq: r_seq};
                end
            end
            S_WDEC: begin
                if (out_free && r_rd.kept && r_rd.seq == r_idx) begin
                    mem_we = 1'b1;
                    mem_wd = '{kept: 1'b0, seq: r_rd.seq};
                end
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_range      <= RANGE_RST;
            r_unrel_exp  <= '0;
            r_unord_recv <= '0;
            r_unord_last <= '0;
            r_unord_bm   <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_chan_recv[i] <= '0;
                r_chan_last[i] <= '0;
            end
            r_addr <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_range <= i_cfg_wdata;
            end
            if (o_vrd.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == SLOT_W'(NSLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_pkt.valid) begin
                        r_seq   <= i_pkt.sequence_no;
                        r_rel   <= i_pkt.reliable;
                        r_ord   <= i_pkt.ordered;
                        r_ch    <= i_pkt.channel_id;
                        r_chk   <= i_pkt.chunk;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_rel && r_ord && ch_ok && !c_back && (c_inord || c_d < WIN)) begin
                        // reorder path: find the slot first
                        r_inord <= c_inord;
                        if (POW2) begin
                            r_racc  <= {1'b0, r_seq[REM_W-1:0]};
                            r_state <= S_RDONE;
                        end else begin
                            r_state <= S_REM;
                        end
                    end else if (out_free) begin
                        r_ov       <= 1'b1;
                        r_o_status <= ST_OOW;
                        r_o_dv     <= 1'b0;
                        r_o_seq    <= r_seq;
                        r_o_fc     <= 1'b0;
                        r_o_slot   <= '0;
                        r_o_ra     <= 1'b0;
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                        if (!r_rel) begin
                            if (unrel_d != '0 && unrel_d < r_range) begin
                                r_o_status  <= ST_DELIVER;
                                r_o_dv      <= 1'b1;
                                r_unrel_exp <= r_seq;
                            end
                        end else if (r_ord) begin
                            if (!ch_ok) begin
                                r_o_status <= ST_BADCH;
                            end else if (c_back) begin
                                r_o_status <= ST_DUP;
                            end
                        end else if (u_back) begin
                            r_o_status <= ST_DUP;
                        end else if (u_inord) begin
                            r_o_status   <= ST_DELIVER;
                            r_o_dv       <= 1'b1;
                            r_o_ra       <= r_chk;
                            r_upd        <= (r_unord_recv == r_unord_last);
                            r_unord_recv <= r_seq;
                            r_unord_bm   <= r_unord_bm >> 1;
                            r_state      <= S_UWALK;
                        end else if (u_d < WIN) begin
                            if ((r_seq - r_unord_last) < WIN) begin
                                r_unord_last <= r_seq;
                            end
                            if (r_unord_bm[bit_idx]) begin
                                r_o_status <= ST_DUP;
                            end else begin
                                r_unord_bm[bit_idx] <= 1'b1;
                                r_o_status <= ST_DELIVER;
                                r_o_dv     <= 1'b1;
                                r_o_ra     <= r_chk;
                            end
                        end
                    end
                end
                S_REM: begin
                    r_quo   <= prod[2*SEQ_W-1:SEQ_W];
                    r_state <= S_RFIX;
                end
                S_RFIX: begin
                    r_racc  <= rem_raw[REM_W:0];
                    r_state <= S_RDONE;
                end
                S_RDONE: begin
                    if (r_inord) begin
                        r_upd          <= (c_recv == c_last);
                        r_chan_recv[chi] <= r_seq;
                        r_p_seq        <= r_seq;
                        r_p_fc         <= 1'b0;
                        r_p_slot       <= '0;
                        r_idx          <= r_seq;
                        r_rem          <= rem_now;
                        r_cnt          <= '0;
                        r_state        <= S_WCHK;
                    end else begin
                        r_addr  <= base + SLOT_W'(rem_now);
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_ORD;
                S_ORD: begin
                    if (out_free) begin
                        if ((r_seq - c_last) < WIN) begin
                            r_chan_last[chi] <= r_seq;
                        end
                        r_ov     <= 1'b1;
                        r_o_dv   <= 1'b0;
                        r_o_seq  <= r_seq;
                        r_o_fc   <= 1'b0;
                        r_o_ra   <= 1'b0;
                        r_o_last <= 1'b1;
                        if (r_rd.kept && r_rd.seq == r_seq) begin
                            r_o_status <= ST_DUP;
                            r_o_slot   <= '0;
                        end else begin
                            r_o_status <= ST_CACHED;
                            r_o_slot   <= r_addr;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_WCHK: begin
                    if (r_idx == c_last || r_cnt == CNT_W'(WINDOW - 2)) begin
                        if (out_free) begin
                            r_ov       <= 1'b1;
                            r_o_status <= ST_DELIVER;
                            r_o_dv     <= 1'b1;
                            r_o_seq    <= r_p_seq;
                            r_o_fc     <= r_p_fc;
                            r_o_slot   <= r_p_slot;
                            r_o_ra     <= 1'b0;
                            r_o_last   <= 1'b1;
                            if (r_upd) begin
                                r_chan_last[chi] <= c_recv;
                            end
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_rem   <= rem_nx;
                        r_addr  <= base + SLOT_W'(rem_nx);
                        r_state <= S_WRD;
                    end
                end
                S_WRD: r_state <= S_WDEC;
                S_WDEC: begin
                    if (out_free) begin
                        r_ov       <= 1'b1;
                        r_o_status <= ST_DELIVER;
                        r_o_dv     <= 1'b1;
                        r_o_seq    <= r_p_seq;
                        r_o_fc     <= r_p_fc;
                        r_o_slot   <= r_p_slot;
                        r_o_ra     <= 1'b0;
                        if (r_rd.kept && r_rd.seq == r_idx) begin
                            // hold the release beat until the next slot is known
                            r_o_last         <= 1'b0;
                            r_p_seq          <= r_idx;
                            r_p_fc           <= 1'b1;
                            r_p_slot         <= r_addr;
                            r_chan_recv[chi] <= c_recv + 1'b1;
                            r_cnt            <= r_cnt + 1'b1;
                            r_state          <= S_WCHK;
                        end else begin
                            r_o_last <= 1'b1;
                            if (r_upd) begin
                                r_chan_last[chi] <= c_recv;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_UWALK: begin
                    // absorb consecutive marks ahead of the in-order point
                    if (r_unord_bm[0]) begin
                        r_unord_bm   <= r_unord_bm >> 1;
                        r_unord_recv <= r_unord_recv + 1'b1;
                    end else begin
                        if (r_upd) begin
                            r_unord_last <= r_unord_recv;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_pkt.ready         = (r_state == S_IDLE);
    assign o_vrd.valid         = r_ov;
    assign o_vrd.status        = r_o_status;
    assign o_vrd.deliver       = r_o_dv;
    assign o_vrd.delivered_seq = r_o_seq;
    assign o_vrd.from_cache    = r_o_fc;
    assign o_vrd.buffer_slot   = SLOT_OUT_W'(r_o_slot);
    assign o_vrd.to_reassembly = r_o_ra;
    assign o_vrd.last          = r_o_last;

    `RURW_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !i_pkt.ready)
    `RURW_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_pkt.valid && i_pkt.ready, !i_pkt.ready)
    `RURW_ASSERT_IMP(a_walk_bound, i_clk, i_rst_n, r_state == S_WDEC,
        r_cnt < CNT_W'(WINDOW - 2))
    `RURW_ASSERT_IMP(a_slot_in_range, i_clk, i_rst_n, mem_we && r_state != S_CLEAR,
        {1'b0, mem_wa} < (SLOT_W + 1)'(NSLOTS))

endmodule

// ===== test/tb_reliable_udp_receive_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receive window testbench
// Drives packet headers through the valid/ready channel under several
// idle/stall mixes and range settings. A local model of the sequence window,
// duplicate bitmaps and reorder slots predicts every verdict beat, which is
// compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_reliable_udp_receive_window;
    import rurw_pkg::*;

    localparam int WIN     = WINDOW_DEF;
    localparam int NCHAN   = CHANNELS_DEF;
    localparam int NSLOT   = WIN * NCHAN;
    localparam int PHASE_N = 90;

    typedef struct {
        logic [SEQ_W-1:0]  seq;
        logic              rel;
        logic              ord;
        logic [CHID_W-1:0] ch;
        logic              chk;
        bit                hold;
    } header_t;

    typedef struct {
        t_status               status;
        logic                  deliver;
        logic [SEQ_W-1:0]      dseq;
        logic                  from_cache;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  reas;
        logic                  last;
    } verdict_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [SEQ_W-1:0] i_cfg_wdata;

    rurw_in_if  pkt_if ();
    rurw_out_if vrd_if ();

    reliable_udp_receive_window dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pkt       (pkt_if),
        .o_vrd       (vrd_if)
    );

    header_t  header_q[$];
    verdict_t verdict_q[$];
    int       errors;
    int       send_idle_pct;
    int       recv_stall_pct;
    logic     hdr_taken;

    // window model state
    logic [SEQ_W-1:0] accept_range;
    logic [SEQ_W-1:0] unrel_seq;
    logic [SEQ_W-1:0] unord_recv, unord_last;
    logic [63:0]      unord_map;
    logic [SEQ_W-1:0] chan_recv [NCHAN];
    logic [SEQ_W-1:0] chan_last [NCHAN];
    logic [63:0]      chan_map  [NCHAN];
    bit               slot_kept [NSLOT];
    logic [SEQ_W-1:0] slot_seq  [NSLOT];

    // stimulus generator bookkeeping
    logic [SEQ_W-1:0] gen_unrel, gen_unord;
    logic [SEQ_W-1:0] gen_chan [NCHAN];

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        errors++;
    endtask

    function automatic void push_verdict(t_status st, logic dv, logic [SEQ_W-1:0] s,
                                         logic fc, logic [SLOT_OUT_W-1:0] slot, logic ra);
        verdict_t v;
        v.status = st; v.deliver = dv; v.dseq = s; v.from_cache = fc;
        v.slot = slot; v.reas = ra; v.last = 1'b0;
        verdict_q.push_back(v);
    endfunction

    function automatic logic [SLOT_OUT_W-1:0] slot_of(int ch, logic [SEQ_W-1:0] s);
        return SLOT_OUT_W'(ch * WIN + int'(s % WIN));
    endfunction

    function automatic void judge_unordered(logic [SEQ_W-1:0] s, logic chk);
        logic [SEQ_W-1:0] d;
        logic [63:0]      bitm;
        bit               upd;
        if (unord_recv - s < WIN) begin
            push_verdict(ST_DUP, 0, s, 0, 0, 0);
        end else if (s != unord_recv + 1) begin
            d = s - unord_recv;
            if (d >= WIN) begin
                push_verdict(ST_OOW, 0, s, 0, 0, 0);
                return;
            end
            if (s - unord_last < WIN) unord_last = s;
            bitm = 64'd1 << ((d - 1) & 63);
            if ((unord_map & bitm) != 0) begin
                push_verdict(ST_DUP, 0, s, 0, 0, 0);
                return;
            end
            unord_map |= bitm;
            push_verdict(ST_DELIVER, 1, s, 0, 0, chk);
        end else begin
            upd = (unord_recv == unord_last);
            unord_recv = s;
            unord_map >>= 1;
            push_verdict(ST_DELIVER, 1, s, 0, 0, chk);
            while (unord_map[0]) begin
                unord_map >>= 1;
                unord_recv++;
            end
            if (upd) unord_last = unord_recv;
        end
    endfunction

    function automatic void judge_ordered(logic [SEQ_W-1:0] s, int ch);
        logic [SEQ_W-1:0] d, idx;
        int               sl, cnt;
        bit               upd;
        if (ch >= NCHAN) begin
            push_verdict(ST_BADCH, 0, s, 0, 0, 0);
        end else if (chan_recv[ch] - s < WIN) begin
            push_verdict(ST_DUP, 0, s, 0, 0, 0);
        end else if (s != chan_recv[ch] + 1) begin
            d = s - chan_recv[ch];
            if (d >= WIN) begin
                push_verdict(ST_OOW, 0, s, 0, 0, 0);
                return;
            end
            if (s - chan_last[ch] < WIN) chan_last[ch] = s;
            sl = ch * WIN + int'(s % WIN);
            if (slot_kept[sl] && slot_seq[sl] == s) begin
                push_verdict(ST_DUP, 0, s, 0, 0, 0);
                return;
            end
            slot_kept[sl] = 1;
            slot_seq[sl] = s;
            chan_map[ch] |= 64'd1 << ((d - 1) & 63);
            push_verdict(ST_CACHED, 0, s, 0, slot_of(ch, s), 0);
        end else begin
            upd = (chan_recv[ch] == chan_last[ch]);
            push_verdict(ST_DELIVER, 1, s, 0, 0, 0);
            chan_map[ch] >>= 1;
            chan_recv[ch] = s;
            idx = s;
            cnt = 0;
            // walk the cached run that follows, bounded so one header stays within 63 beats
            while (idx != chan_last[ch] && cnt < WIN - 2) begin
                idx++;
                sl = ch * WIN + int'(idx % WIN);
                if (!slot_kept[sl] || slot_seq[sl] != idx) break;
                push_verdict(ST_DELIVER, 1, idx, 1, slot_of(ch, idx), 0);
                slot_kept[sl] = 0;
                chan_recv[ch]++;
                chan_map[ch] >>= 1;
                cnt++;
            end
            if (upd) chan_last[ch] = chan_recv[ch];
        end
    endfunction

    function automatic void judge_header(header_t h);
        logic [SEQ_W-1:0] d;
        if (!h.rel) begin
            d = h.seq - unrel_seq;
            if (d == 0 || d >= accept_range) begin
                push_verdict(ST_OOW, 0, h.seq, 0, 0, 0);
            end else begin
                push_verdict(ST_DELIVER, 1, h.seq, 0, 0, 0);
                unrel_seq = h.seq;
            end
        end else if (!h.ord) begin
            judge_unordered(h.seq, h.chk);
        end else begin
            judge_ordered(h.seq, int'(h.ch));
        end
        verdict_q[verdict_q.size() - 1].last = 1'b1;
    endfunction

    // driver: change inputs on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            vrd_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!pkt_if.valid || hdr_taken) begin
                if (header_q.size() != 0 && !(header_q[0].hold && verdict_q.size() != 0)
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    pkt_if.valid       <= 1'b1;
                    pkt_if.sequence_no <= header_q[0].seq;
                    pkt_if.reliable    <= header_q[0].rel;
                    pkt_if.ordered     <= header_q[0].ord;
                    pkt_if.channel_id  <= header_q[0].ch;
                    pkt_if.chunk       <= header_q[0].chk;
                    void'(header_q.pop_front());
                end else begin
                    pkt_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: predict on header beats, check verdict beats
    always @(posedge i_clk) begin
        verdict_t v;
        header_t  h;
        hdr_taken <= pkt_if.valid && pkt_if.ready;
        if (i_rst_n && pkt_if.valid && pkt_if.ready) begin
            h.seq = pkt_if.sequence_no; h.rel = pkt_if.reliable; h.ord = pkt_if.ordered;
            h.ch = pkt_if.channel_id; h.chk = pkt_if.chunk; h.hold = 0;
            judge_header(h);
        end
        if (i_rst_n && vrd_if.valid && vrd_if.ready) begin
            if (verdict_q.size() == 0) begin
                report($sformatf("verdict beat with nothing expected, seq %h",
                                 vrd_if.delivered_seq));
            end else begin
                v = verdict_q.pop_front();
                if (vrd_if.status !== v.status)
                    report($sformatf("status %0d, want %0d (seq %h)",
                                     vrd_if.status, v.status, v.dseq));
                if (vrd_if.deliver !== v.deliver)
                    report($sformatf("deliver %b, want %b (seq %h)",
                                     vrd_if.deliver, v.deliver, v.dseq));
                if (vrd_if.delivered_seq !== v.dseq)
                    report($sformatf("delivered_seq %h, want %h",
                                     vrd_if.delivered_seq, v.dseq));
                if (vrd_if.from_cache !== v.from_cache)
                    report($sformatf("from_cache %b, want %b (seq %h)",
                                     vrd_if.from_cache, v.from_cache, v.dseq));
                if (vrd_if.buffer_slot !== v.slot)
                    report($sformatf("buffer_slot %0d, want %0d (seq %h)",
                                     vrd_if.buffer_slot, v.slot, v.dseq));
                if (vrd_if.to_reassembly !== v.reas)
                    report($sformatf("to_reassembly %b, want %b (seq %h)",
                                     vrd_if.to_reassembly, v.reas, v.dseq));
                if (vrd_if.last !== v.last)
                    report($sformatf("last %b, want %b (seq %h)",
                                     vrd_if.last, v.last, v.dseq));
            end
        end
    end

    function automatic void add_header(logic [SEQ_W-1:0] s, logic rel, logic ord,
                                       logic [CHID_W-1:0] ch, logic chk, bit hold);
        header_t h;
        h.seq = s; h.rel = rel; h.ord = ord; h.ch = ch; h.chk = chk; h.hold = hold;
        header_q.push_back(h);
    endfunction

    // queue a shuffled run of reliable headers; with in_order_last, base+1 comes last and closes the gap
    function automatic int add_run(bit ord, int ch, int len, bit in_order_last);
        logic [SEQ_W-1:0] run [$];
        logic [SEQ_W-1:0] base, tmp;
        int               j;
        base = ord ? gen_chan[ch] : gen_unord;
        for (int i = 1; i <= len; i++) run.push_back(base + i);
        for (int i = len - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = run[i]; run[i] = run[j]; run[j] = tmp;
        end
        if (in_order_last) begin
            for (int i = 0; i < len; i++)
                if (run[i] == base + 1) begin
                    run.delete(i);
                    break;
                end
            run.push_back(base + 1);
        end
        foreach (run[i]) begin
            add_header(run[i], 1, ord, CHID_W'(ch), 1'($urandom_range(0, 1)), 0);
            // replay now and then to hit the duplicate paths
            if ($urandom_range(0, 9) == 0)
                add_header(run[$urandom_range(0, i)], 1, ord, CHID_W'(ch),
                           1'($urandom_range(0, 1)), 0);
        end
        if (ord) gen_chan[ch] = base + len;
        else gen_unord = base + len;
        return run.size();
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (header_q.size() != 0 || verdict_q.size() != 0 || pkt_if.valid
               || !pkt_if.ready);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_range(input logic [SEQ_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        accept_range = value;
    endtask

    task automatic fill_phase(input bit long_walk);
        int n, r, ch;
        n = 0;
        add_header(gen_unrel + 1, 0, 0, 0, 0, 1);
        if (long_walk) begin
            ch = $urandom_range(0, NCHAN - 1);
            n += add_run(1, ch, WIN - 1, 1);
        end
        while (n < PHASE_N) begin
            r = $urandom_range(0, 99);
            ch = $urandom_range(0, NCHAN - 1);
            if (r < 30) begin
                n += add_run(1, ch, $urandom_range(1, 8), 1'($urandom_range(0, 1)));
            end else if (r < 48) begin
                n += add_run(0, 0, $urandom_range(1, 8), 1'($urandom_range(0, 1)));
            end else if (r < 66) begin
                gen_unrel = gen_unrel + $urandom_range(0, 1500);
                add_header(gen_unrel, 0, 1'($urandom_range(0, 1)),
                           CHID_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 0);
                n++;
            end else if (r < 76) begin
                add_header(gen_chan[ch] - $urandom_range(0, 70), 1, 1, CHID_W'(ch),
                           1'($urandom_range(0, 1)), 0);
                n++;
            end else if (r < 84) begin
                add_header(gen_unord + WIN + $urandom_range(0, 5), 1,
                           1'($urandom_range(0, 1)), CHID_W'(ch), 0, 0);
                n++;
            end else if (r < 90) begin
                add_header($urandom, 1, 1, CHID_W'($urandom_range(NCHAN, 31)),
                           1'($urandom_range(0, 1)), 0);
                n++;
            end else begin
                add_header($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           CHID_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 19) == 0);
                n++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        pkt_if.valid = 1'b0;
        pkt_if.sequence_no = '0;
        pkt_if.reliable = 1'b0;
        pkt_if.ordered = 1'b0;
        pkt_if.channel_id = '0;
        pkt_if.chunk = 1'b0;
        vrd_if.ready = 1'b0;
        hdr_taken = 1'b0;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        accept_range = RANGE_RST;
        unrel_seq = '0; unord_recv = '0; unord_last = '0; unord_map = '0;
        for (int i = 0; i < NCHAN; i++) begin
            chan_recv[i] = '0; chan_last[i] = '0; chan_map[i] = '0;
        end
        for (int i = 0; i < NSLOT; i++) begin
            slot_kept[i] = 0; slot_seq[i] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: unreliable edges
        add_header(32'd0, 0, 0, 0, 0, 0);
        add_header(32'd5, 0, 1, 31, 1, 0);
        add_header(32'd5 + 32'd1024, 0, 0, 0, 0, 0);
        add_header(32'd1028, 0, 0, 0, 0, 0);
        add_header(32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        // unordered: in order, early, replay, gap fill, far ahead, behind
        add_header(32'd1, 1, 0, 0, 1, 0);
        add_header(32'd3, 1, 0, 0, 1, 0);
        add_header(32'd3, 1, 0, 0, 0, 0);
        add_header(32'd2, 1, 0, 0, 0, 0);
        add_header(32'h8000_0000, 1, 0, 0, 0, 0);
        add_header(32'd1, 1, 0, 0, 0, 0);
        add_header(32'd3 + WIN, 1, 0, 0, 0, 0);
        // ordered: cache, duplicate in slot, release walk, bad channels, out of window
        add_header(32'd2, 1, 1, 0, 0, 0);
        add_header(32'd2, 1, 1, 0, 1, 0);
        add_header(32'd1, 1, 1, 0, 0, 0);
        add_header(32'd1, 1, 1, 0, 0, 0);
        add_header(32'd7, 1, 1, CHID_W'(NCHAN), 0, 0);
        add_header(32'hFFFF_FFFF, 1, 1, 31, 1, 0);
        add_header(32'd2 + WIN, 1, 1, 0, 0, 0);
        add_header(32'd3, 1, 1, CHID_W'(NCHAN - 1), 0, 0);
        add_header(32'd1, 1, 1, CHID_W'(NCHAN - 1), 0, 0);
        gen_unrel = 32'hFFFF_FFFF;
        gen_unord = 32'd3;
        for (int i = 0; i < NCHAN; i++) gen_chan[i] = '0;
        gen_chan[0] = 32'd2;
        gen_chan[NCHAN - 1] = 32'd3;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_range(32'd1);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    write_range(32'hFFFF_FFFF);
                    send_idle_pct = 73; recv_stall_pct = 0;
                end
                2: begin
                    write_range($urandom_range(2, 5000));
                    send_idle_pct = 0;  recv_stall_pct = 73;
                end
                default: begin
                    write_range(RANGE_RST);
                    send_idle_pct = 10; recv_stall_pct = 10;
                end
            endcase
            fill_phase(ph == 0 || ph == 3);
        end

        wait_idle();
        repeat (200) @(negedge i_clk);
        if (errors == 0)
            $display("reliable_udp_receive_window test passed");
        else
            $display("reliable_udp_receive_window test failed");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("reliable_udp_receive_window test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rurw_pkg.sv
sv/rurw_ifs.sv
sv/reliable_udp_receive_window.sv
test/tb_reliable_udp_receive_window.sv
